@@ rtl/euler_pose_to_quaternion_defines.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the pose to quaternion block
// Shared assertion forms used by the port checker.
// ---------------------------------------------------------------------------
`ifndef EULER_POSE_TO_QUATERNION_DEFINES_SVH
`define EULER_POSE_TO_QUATERNION_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define EPQ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("epq assertion failed");

// next-cycle implication, disabled while in reset
`define EPQ_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("epq assertion failed");

`endif

@@ rtl/epq_pkg.sv @@
// ---------------------------------------------------------------------------
// epq_pkg
// Constants and types shared by the pose to quaternion pipeline.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package epq_pkg;

  // sincos unit latency and length of the side-band delay line
  localparam int SC_LAT   = 25;
  localparam int SIDE_LEN = SC_LAT + 4;

  // register indexes on the config port
  localparam logic [1:0] REG_OFFSET_X = 2'd0;
  localparam logic [1:0] REG_OFFSET_Y = 2'd1;
  localparam logic [1:0] REG_OFFSET_Z = 2'd2;
  localparam logic [1:0] REG_NONE     = 2'd3;

  localparam logic [31:0] OFFSET_X_RST = 32'd20903867;
  localparam logic [31:0] OFFSET_Y_RST = 32'd12835182;
  localparam logic [31:0] OFFSET_Z_RST = 32'd0;

  // angle to radians: floor(pi_q30 / 45) and pi_q30 mod 45
  localparam logic [26:0] PI_DIV45   = 27'd74961320;
  localparam logic [4:0]  PI_MOD45   = 5'd26;
  localparam logic [15:0] RECIP23040 = 16'((64'd1 << 30) / 64'd23040);

  // Taylor step divisors and their reciprocals (2^33 scale)
  localparam logic [7:0] SIN_DIV [6] = '{8'd6, 8'd20, 8'd42, 8'd72, 8'd110, 8'd156};
  localparam logic [7:0] COS_DIV [6] = '{8'd2, 8'd12, 8'd30, 8'd56, 8'd90, 8'd132};
  localparam logic [32:0] SIN_RECIP [6] = '{
    33'((64'd1 << 33) / 64'd6),   33'((64'd1 << 33) / 64'd20),
    33'((64'd1 << 33) / 64'd42),  33'((64'd1 << 33) / 64'd72),
    33'((64'd1 << 33) / 64'd110), 33'((64'd1 << 33) / 64'd156)};
  localparam logic [32:0] COS_RECIP [6] = '{
    33'((64'd1 << 33) / 64'd2),   33'((64'd1 << 33) / 64'd12),
    33'((64'd1 << 33) / 64'd30),  33'((64'd1 << 33) / 64'd56),
    33'((64'd1 << 33) / 64'd90),  33'((64'd1 << 33) / 64'd132)};

  typedef struct packed {
    logic [31:0] sec;
    logic [29:0] nsec;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
  } side_t;

endpackage

@@ rtl/epq_sincos.sv @@
// ---------------------------------------------------------------------------
// epq_sincos
// Pipelined sine/cosine of a half angle in 1/128 degree, Q2.14 results.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module epq_sincos import epq_pkg::*; (
  input  logic               clk,
  input  logic               ce,
  input  logic signed [16:0] angle,
  output logic signed [15:0] sin_q14,
  output logic signed [15:0] cos_q14
);

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  // stage A: wrap to one turn, split into quadrant and rest
  logic [15:0] m;
  logic [1:0]  qa_nxt, qa_r;
  logic [13:0] ra_nxt, ra_r;

  always_comb begin
    m = angle[16] ? 16'($unsigned(angle + 17'sd46080)) : 16'($unsigned(angle));
    priority if (m >= 16'd34560) begin
      qa_nxt = QUAD_3;
      ra_nxt = 14'(m - 16'd34560);
    end else if (m >= 16'd23040) begin
      qa_nxt = QUAD_2;
      ra_nxt = 14'(m - 16'd23040);
    end else if (m >= 16'd11520) begin
      qa_nxt = QUAD_1;
      ra_nxt = 14'(m - 16'd11520);
    end else begin
      qa_nxt = QUAD_0;
      ra_nxt = m[13:0];
    end
  end

  // stage B: r*pi = 45*r*floor(pi/45) + 26*r
  logic [40:0] yb_r;
  logic [18:0] cb_r;
  logic [1:0]  qb_r;
  // stage C: small remainder term and its reciprocal product
  logic [18:0] w_nxt, wc_r;
  logic [34:0] pc_r;
  logic [31:0] yh_r;
  logic [1:0]  qc_r;
  // stage D: corrected quotient gives x in Q30
  logic [4:0]  q0d;
  logic [19:0] remd;
  logic [31:0] x_r;
  logic [1:0]  qd_r;
  // stage E: x squared
  logic [63:0] xx_r;
  logic [31:0] xe_r;
  logic [1:0]  qe_r;

  assign w_nxt = 19'(19'(ra_r) * 19'd0) + 19'(45 * yb_r[8:0]) + cb_r;
  assign q0d   = pc_r[34:30];
  assign remd  = 20'(wc_r) - 20'(20'(q0d) * 20'd23040);

  always_ff @(posedge clk) begin
    if (ce) begin
      qa_r <= qa_nxt;
      ra_r <= ra_nxt;
      yb_r <= 41'(ra_r) * 41'(PI_DIV45);
      cb_r <= 19'(19'(ra_r) * 19'(PI_MOD45)) + 19'd11520;
      qb_r <= qa_r;
      wc_r <= w_nxt;
      pc_r <= 35'(w_nxt) * 35'(RECIP23040);
      yh_r <= yb_r[40:9];
      qc_r <= qb_r;
      x_r  <= yh_r + 32'(q0d) + ((remd >= 20'd23040) ? 32'd1 : 32'd0);
      qd_r <= qc_r;
      xx_r <= 64'(x_r) * 64'(x_r);
      xe_r <= x_r;
      qe_r <= qd_r;
    end
  end

  // Taylor series state at each step boundary
  logic [31:0]        x2_b [0:6];
  logic [32:0]        st_b [0:6];
  logic [32:0]        ct_b [0:6];
  logic signed [34:0] ss_b [0:6];
  logic signed [34:0] cs_b [0:6];
  logic [1:0]         q_b  [0:6];

  // stage F: round x^2 back to Q30, seed the series
  logic [63:0] xx_rnd;
  assign xx_rnd = (xx_r + (64'd1 << 29)) >> 30;

  always_ff @(posedge clk) begin
    if (ce) begin
      x2_b[0] <= xx_rnd[31:0];
      st_b[0] <= 33'(xe_r);
      ct_b[0] <= 33'd1 << 30;
      ss_b[0] <= $signed(35'(xe_r));
      cs_b[0] <= $signed(35'd1 << 30);
      q_b[0]  <= qe_r;
    end
  end

  for (genvar k = 0; k < 6; k++) begin : g_step
    logic [64:0]        ps_r, pc1_r;
    logic [31:0]        x2a_r, x2c_r;
    logic signed [34:0] ssa_r, csa_r, ssc_r, csc_r;
    logic [1:0]         qa1_r, qc1_r;
    logic [64:0]        ns_full, nc_full;
    logic [32:0]        ns_r, nc_r;
    logic [65:0]        prs_r, prc_r;
    logic [32:0]        qs0, qcs0, qs, qcs;
    logic [33:0]        rems, remc;

    assign ns_full = (ps_r + (65'd1 << 29)) >> 30;
    assign nc_full = (pc1_r + (65'd1 << 29)) >> 30;
    assign qs0  = prs_r[65:33];
    assign qcs0 = prc_r[65:33];
    assign rems = 34'(ns_r) - 34'(34'(qs0) * 34'(SIN_DIV[k]));
    assign remc = 34'(nc_r) - 34'(34'(qcs0) * 34'(COS_DIV[k]));
    assign qs   = (rems >= 34'(SIN_DIV[k])) ? qs0 + 33'd1 : qs0;
    assign qcs  = (remc >= 34'(COS_DIV[k])) ? qcs0 + 33'd1 : qcs0;

    always_ff @(posedge clk) begin
      if (ce) begin
        ps_r  <= 65'(st_b[k]) * 65'(x2_b[k]);
        pc1_r <= 65'(ct_b[k]) * 65'(x2_b[k]);
        x2a_r <= x2_b[k];
        ssa_r <= ss_b[k];
        csa_r <= cs_b[k];
        qa1_r <= q_b[k];

        ns_r  <= ns_full[32:0];
        nc_r  <= nc_full[32:0];
        prs_r <= 66'(ns_full[32:0]) * 66'(SIN_RECIP[k]);
        prc_r <= 66'(nc_full[32:0]) * 66'(COS_RECIP[k]);
        x2c_r <= x2a_r;
        ssc_r <= ssa_r;
        csc_r <= csa_r;
        qc1_r <= qa1_r;

        x2_b[k+1] <= x2c_r;
        st_b[k+1] <= qs;
        ct_b[k+1] <= qcs;
        // steps with even k subtract, steps with odd k add
        if ((k % 2) == 0) begin
          ss_b[k+1] <= ssc_r - $signed({2'b00, qs});
          cs_b[k+1] <= csc_r - $signed({2'b00, qcs});
        end else begin
          ss_b[k+1] <= ssc_r + $signed({2'b00, qs});
          cs_b[k+1] <= csc_r + $signed({2'b00, qcs});
        end
        q_b[k+1] <= qc1_r;
      end
    end
  end

  // stage G: clamp, round to Q14, apply quadrant
  logic signed [34:0] ssp, csp, svw, cvw;
  logic signed [15:0] sv, cv, sin_r, cos_r;

  always_comb begin
    ssp = ss_b[6][34] ? 35'sd0 : ss_b[6];
    csp = cs_b[6][34] ? 35'sd0 : cs_b[6];
    svw = (ssp + 35'sd32768) >>> 16;
    cvw = (csp + 35'sd32768) >>> 16;
    sv  = svw[15:0];
    cv  = cvw[15:0];
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      unique case (q_b[6])
        QUAD_0: begin sin_r <= sv;  cos_r <= cv;  end
        QUAD_1: begin sin_r <= cv;  cos_r <= -sv; end
        QUAD_2: begin sin_r <= -sv; cos_r <= -cv; end
        QUAD_3: begin sin_r <= -cv; cos_r <= sv;  end
        default: begin sin_r <= sv; cos_r <= cv; end
      endcase
    end
  end

  assign sin_q14 = sin_r;
  assign cos_q14 = cos_r;

endmodule

@@ rtl/euler_pose_to_quaternion.sv @@
// Throughput: one pose per cycle; the whole pipeline advances together and
// holds while the output register is full and not taken.
// Reset (synchronous, rst_n low): clears valid bits and restores the map
// offsets to their defaults; data registers are not reset.
// ---------------------------------------------------------------------------
// euler_pose_to_quaternion
// Pose sample to unit quaternion plus offset map position, fully pipelined.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module euler_pose_to_quaternion import epq_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // stamp_sec, stamp_nsec, trans_x, trans_y, trans_z, rot_x_deg, rot_y_deg, rot_z_deg
  input  logic [207:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // out_sec, out_nsec, pos_x, pos_y, pos_z, quat_w, quat_x, quat_y, quat_z
  output logic [223:0] out_tdata,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [3:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  logic ce;
  logic out_tvalid_r;
  assign ce        = !out_tvalid_r || out_tready;
  assign in_tready = ce;

  // config registers
  logic [31:0] off_x_r, off_y_r, off_z_r;
  logic [1:0]  reg_idx;
  logic        cfg_wr;

  assign reg_idx    = cfg_paddr[3:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_x_r <= OFFSET_X_RST;
      off_y_r <= OFFSET_Y_RST;
      off_z_r <= OFFSET_Z_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_OFFSET_X: off_x_r <= cfg_pwdata;
        REG_OFFSET_Y: off_y_r <= cfg_pwdata;
        REG_OFFSET_Z: off_z_r <= cfg_pwdata;
        REG_NONE:     ;
        default:      ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_OFFSET_X: cfg_prdata = off_x_r;
      REG_OFFSET_Y: cfg_prdata = off_y_r;
      REG_OFFSET_Z: cfg_prdata = off_z_r;
      default:      cfg_prdata = 32'd0;
    endcase
  end

  // input fields
  logic signed [31:0] trans_x, trans_y, trans_z;
  logic signed [15:0] rot_x_deg, rot_y_deg, rot_z_deg;
  assign trans_x   = $signed(in_tdata[93:62]);
  assign trans_y   = $signed(in_tdata[125:94]);
  assign trans_z   = $signed(in_tdata[157:126]);
  assign rot_x_deg = $signed(in_tdata[173:158]);
  assign rot_y_deg = $signed(in_tdata[189:174]);
  assign rot_z_deg = $signed(in_tdata[205:190]);

  // position sums (y is offset minus translation) with saturation
  logic signed [32:0] sum_x, sum_y, sum_z;
  side_t side_nxt;

  function automatic logic [31:0] sat32(input logic signed [32:0] v);
    logic [31:0] r;
    if (v[32] != v[31]) r = v[32] ? 32'h8000_0000 : 32'h7fff_ffff;
    else r = v[31:0];
    return r;
  endfunction

  always_comb begin
    sum_x = 33'(trans_x) + 33'($signed(off_x_r));
    sum_y = 33'($signed(off_y_r)) - 33'(trans_y);
    sum_z = 33'(trans_z) + 33'($signed(off_z_r));
    side_nxt.sec   = in_tdata[31:0];
    side_nxt.nsec  = in_tdata[61:32];
    side_nxt.pos_x = sat32(sum_x);
    side_nxt.pos_y = sat32(sum_y);
    side_nxt.pos_z = sat32(sum_z);
  end

  // stage 1: angles (pitch and yaw negated)
  logic signed [16:0] roll_r, pitch_r, yaw_r;
  side_t side_r [SIDE_LEN];
  logic  [SIDE_LEN-1:0] v_r;

  always_ff @(posedge clk) begin
    if (ce) begin
      roll_r    <= 17'(rot_z_deg);
      pitch_r   <= -17'(rot_x_deg);
      yaw_r     <= -17'(rot_y_deg);
      side_r[0] <= side_nxt;
      for (int i = 1; i < SIDE_LEN; i++) side_r[i] <= side_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r          <= '0;
      out_tvalid_r <= 1'b0;
    end else if (ce) begin
      v_r          <= {v_r[SIDE_LEN-2:0], in_tvalid};
      out_tvalid_r <= v_r[SIDE_LEN-1];
    end
  end

  logic signed [15:0] sr, cr, sp, cp, sy, cy;

  epq_sincos u_roll  (.clk(clk), .ce(ce), .angle(roll_r),  .sin_q14(sr), .cos_q14(cr));
  epq_sincos u_pitch (.clk(clk), .ce(ce), .angle(pitch_r), .sin_q14(sp), .cos_q14(cp));
  epq_sincos u_yaw   (.clk(clk), .ce(ce), .angle(yaw_r),   .sin_q14(sy), .cos_q14(cy));

  // roll/pitch pair products, then times yaw terms, then sums (Q42)
  logic signed [31:0] p_cc_r, p_ss_r, p_sc_r, p_cs_r;
  logic signed [15:0] sy_r, cy_r;
  logic signed [47:0] w1_r, w2_r, x1_r, x2_r, y1_r, y2_r, z1_r, z2_r;
  logic signed [48:0] qw_r, qx_r, qy_r, qz_r;

  always_ff @(posedge clk) begin
    if (ce) begin
      p_cc_r <= 32'(cr) * 32'(cp);
      p_ss_r <= 32'(sr) * 32'(sp);
      p_sc_r <= 32'(sr) * 32'(cp);
      p_cs_r <= 32'(cr) * 32'(sp);
      sy_r   <= sy;
      cy_r   <= cy;
      w1_r <= 48'(p_cc_r) * 48'(cy_r);
      w2_r <= 48'(p_ss_r) * 48'(sy_r);
      x1_r <= 48'(p_sc_r) * 48'(cy_r);
      x2_r <= 48'(p_cs_r) * 48'(sy_r);
      y1_r <= 48'(p_cs_r) * 48'(cy_r);
      y2_r <= 48'(p_sc_r) * 48'(sy_r);
      z1_r <= 48'(p_cc_r) * 48'(sy_r);
      z2_r <= 48'(p_ss_r) * 48'(cy_r);
      qw_r <= 49'(w1_r) + 49'(w2_r);
      qx_r <= 49'(x1_r) - 49'(x2_r);
      qy_r <= 49'(y1_r) + 49'(y2_r);
      qz_r <= 49'(z1_r) - 49'(z2_r);
    end
  end

  // Q42 to Q14, half away from zero, clamped to +-1.0
  function automatic logic [15:0] to_q14(input logic signed [48:0] v);
    logic [48:0] mag, rnd;
    logic [15:0] r;
    mag = v[48] ? 49'(-v) : 49'(v);
    rnd = (mag + (49'd1 << 27)) >> 28;
    r   = (rnd > 49'd16384) ? 16'd16384 : rnd[15:0];
    return v[48] ? 16'(-r) : r;
  endfunction

  logic [223:0] out_tdata_r;
  side_t        side_last;
  assign side_last = side_r[SIDE_LEN-1];

  always_ff @(posedge clk) begin
    if (ce) begin
      out_tdata_r <= {2'b00, to_q14(qz_r), to_q14(qy_r), to_q14(qx_r), to_q14(qw_r),
                      side_last.pos_z, side_last.pos_y, side_last.pos_x,
                      side_last.nsec, side_last.sec};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

@@ rtl/epq_sva.sv @@
// ---------------------------------------------------------------------------
// epq_sva
// Port-level checker for the pose to quaternion block, bound to the top.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "euler_pose_to_quaternion_defines.svh"

module epq_sva (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [223:0] out_tdata
);

  // a stalled result holds
  `EPQ_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  // the pipe takes requests exactly when its output can move
  `EPQ_ASSERT_IMP(a_in_ready, 1'b1, in_tready == (!out_tvalid || out_tready))
  // quaternion w part stays within +-1.0 in Q2.14
  `EPQ_ASSERT_IMP(a_quat_w, out_tvalid, ($signed(out_tdata[173:158]) <= 16'sd16384) && ($signed(out_tdata[173:158]) >= -16'sd16384))

endmodule

bind euler_pose_to_quaternion epq_sva u_epq_sva (.*);

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Pose to quaternion testbench
// Drives pose samples over the input stream, rewrites the map offsets over
// APB between phases, and checks every result against a local prediction.
// ---------------------------------------------------------------------------

module testbench;
  import epq_pkg::*;

  localparam longint TURN    = 46080;
  localparam longint QUARTER = 11520;
  localparam longint PI_Q30  = 64'sd3373259426;
  localparam longint ONE_Q30 = 1073741824;
  localparam int     DRAIN   = 40;

  typedef struct packed {
    logic signed [31:0] sec;
    logic [29:0]        nsec;
    logic signed [31:0] tx, ty, tz;
    logic signed [15:0] rx, ry, rz;
  } pose_t;

  typedef struct packed {
    logic signed [31:0] sec;
    logic [29:0]        nsec;
    logic signed [31:0] px, py, pz;
    logic signed [15:0] qw, qx, qy, qz;
  } quat_pose_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [207:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [223:0] out_tdata;
  logic         cfg_psel = 1'b0;
  logic         cfg_penable = 1'b0;
  logic         cfg_pwrite = 1'b0;
  logic [3:0]   cfg_paddr = '0;
  logic [31:0]  cfg_pwdata = '0;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  logic signed [31:0] map_off [3];
  quat_pose_t pending_poses [$];
  int  errors = 0;
  int  poses_sent = 0;
  int  poses_checked = 0;
  bit  steady = 1'b0;        // no random idling on either side
  int  stall_left = 0;

  always #4 clk = ~clk;

  euler_pose_to_quaternion DUT (.*);

  // sin/cos in Q14 of a half angle in 1/128 degree
  function automatic void half_sincos(input longint a, output longint s, output longint c);
    longint m, q, r, x, x2, st, ct, ss, cs, sv, cv;
    m = (a + 2 * TURN) % TURN;
    q = m / QUARTER;
    r = m % QUARTER;
    x = (r * PI_Q30 + QUARTER) / 23040;
    x2 = (x * x + (64'sd1 <<< 29)) >>> 30;
    st = x; ss = x; ct = ONE_Q30; cs = ONE_Q30;
    for (int k = 1; k <= 6; k++) begin
      st = ((st * x2 + (64'sd1 <<< 29)) >>> 30) / ((2 * k) * (2 * k + 1));
      ct = ((ct * x2 + (64'sd1 <<< 29)) >>> 30) / ((2 * k - 1) * (2 * k));
      if (k % 2 == 1) begin
        ss -= st; cs -= ct;
      end else begin
        ss += st; cs += ct;
      end
    end
    if (ss < 0) ss = 0;
    if (cs < 0) cs = 0;
    sv = (ss + (64'sd1 <<< 15)) >>> 16;
    cv = (cs + (64'sd1 <<< 15)) >>> 16;
    case (q)
      0: begin s = sv;  c = cv;  end
      1: begin s = cv;  c = -sv; end
      2: begin s = -sv; c = -cv; end
      default: begin s = -cv; c = sv; end
    endcase
  endfunction

  function automatic logic signed [15:0] q42_to_q14(input longint v);
    longint r;
    r = (v >= 0) ? (v + (64'sd1 <<< 27)) >>> 28 : -(((-v) + (64'sd1 <<< 27)) >>> 28);
    if (r > 16384) r = 16384;
    if (r < -16384) r = -16384;
    return 16'(r);
  endfunction

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return 32'(v);
  endfunction

  function automatic quat_pose_t predict_quat_pose(input pose_t p);
    quat_pose_t e;
    longint sr, cr, sp, cp, sy, cy;
    half_sincos(longint'(p.rz), sr, cr);
    half_sincos(-longint'(p.rx), sp, cp);
    half_sincos(-longint'(p.ry), sy, cy);
    e.sec  = p.sec;
    e.nsec = p.nsec;
    e.px = clamp32(longint'(p.tx) + longint'(map_off[0]));
    e.py = clamp32(longint'(map_off[1]) - longint'(p.ty));
    e.pz = clamp32(longint'(p.tz) + longint'(map_off[2]));
    e.qw = q42_to_q14(cr * cp * cy + sr * sp * sy);
    e.qx = q42_to_q14(sr * cp * cy - cr * sp * sy);
    e.qy = q42_to_q14(cr * sp * cy + sr * cp * sy);
    e.qz = q42_to_q14(cr * cp * sy - sr * sp * cy);
    return e;
  endfunction

  function automatic bit gap_now();
    return !steady && ($urandom_range(99) < 21);
  endfunction

  task automatic send_pose(input pose_t p);
    while (gap_now()) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b0, p.rz, p.ry, p.rx, p.tz, p.ty, p.tx, p.nsec, p.sec};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_poses.push_back(predict_quat_pose(p));
    poses_sent++;
  endtask

  function automatic pose_t rand_pose();
    pose_t p;
    p.sec  = $urandom;
    p.nsec = ($urandom_range(9) == 0) ? 30'($urandom) : 30'($urandom_range(999999999));
    p.tx = $urandom; p.ty = $urandom; p.tz = $urandom;
    if ($urandom_range(4) == 0) begin
      p.rx = 16'($urandom); p.ry = 16'($urandom); p.rz = 16'($urandom);
    end else begin
      p.rx = 16'($signed($urandom_range(46080)) - 23040);
      p.ry = 16'($signed($urandom_range(46080)) - 23040);
      p.rz = 16'($signed($urandom_range(46080)) - 23040);
    end
    return p;
  endfunction

  // drain, then let the pipeline settle before touching a register
  task automatic quiesce();
    in_tvalid <= 1'b0;
    while (pending_poses.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_offset(input logic [1:0] idx, input logic [31:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (idx != REG_NONE) map_off[idx] = val;
    @(posedge clk);
  endtask

  task automatic set_offsets(input logic [31:0] ox, input logic [31:0] oy,
                             input logic [31:0] oz);
    quiesce();
    write_offset(REG_OFFSET_X, ox);
    write_offset(REG_OFFSET_Y, oy);
    write_offset(REG_OFFSET_Z, oz);
  endtask

  task automatic send_random(input int n);
    repeat (n) send_pose(rand_pose());
  endtask

  task automatic test_directed_angles();
    pose_t p;
    int angs [12] = '{0, 23040, -23040, 11520, -11520, 5760, -5760, 1, -1,
                      32767, -32768, 17280};
    p = '{default: '0};
    foreach (angs[i]) begin
      p.rx = 16'(angs[i]); p.ry = 16'(angs[(i + 4) % 12]); p.rz = 16'(angs[(i + 7) % 12]);
      send_pose(p);
    end
    // position and timestamp extremes, saturation on the high side
    p = '{sec: 32'sh7fffffff, nsec: 30'h3fffffff, tx: 32'sh7fffffff,
          ty: 32'sh80000000, tz: 32'sh7fffffff, rx: 16'sd23040, ry: -16'sd23040,
          rz: 16'sd0};
    send_pose(p);
    p = '{sec: 32'sh80000000, nsec: 30'd999999999, tx: 32'sh80000000,
          ty: 32'sh7fffffff, tz: 32'sh80000000, rx: 16'sh8000, ry: 16'sh7fff,
          rz: -16'sd23040};
    send_pose(p);
    p = '{sec: 32'd0, nsec: 30'd0, tx: '1, ty: '1, tz: '1, rx: '1, ry: '1, rz: '1};
    p.sec = '1;
    send_pose(p);
  endtask

  task automatic test_offset_extremes();
    set_offsets(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    write_offset(REG_NONE, 32'hdeadbeef);
    send_random(40);
    set_offsets(32'h80000000, 32'h80000000, 32'h80000000);
    send_random(40);
    set_offsets(32'h0, 32'hffffffff, 32'h1);
    test_directed_angles();
  endtask

  task automatic test_random_traffic();
    set_offsets($urandom, $urandom, $urandom);
    send_random(120);
    steady = 1'b1;
    send_random(60);
    steady = 1'b0;
  endtask

  task automatic test_backpressure();
    set_offsets($urandom, $urandom, $urandom);
    @(posedge clk);
    stall_left = 120;
    send_random(100);
  endtask

  // result side: readiness and stall counter
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= rst_n && !gap_now();
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      quat_pose_t got, want;
      {got.qz, got.qy, got.qx, got.qw, got.pz, got.py, got.px, got.nsec, got.sec} =
        out_tdata[221:0];
      if (pending_poses.size() == 0) begin
        $display("%0t: result with none expected: %h", $time, out_tdata);
        errors++;
      end else begin
        want = pending_poses.pop_front();
        poses_checked++;
        if (got.sec !== want.sec)
          $display("%0t: sec exp %0d got %0d", $time, want.sec, got.sec);
        if (got.nsec !== want.nsec)
          $display("%0t: nsec exp %0d got %0d", $time, want.nsec, got.nsec);
        if (got.px !== want.px) $display("%0t: pos_x exp %0d got %0d", $time, want.px, got.px);
        if (got.py !== want.py) $display("%0t: pos_y exp %0d got %0d", $time, want.py, got.py);
        if (got.pz !== want.pz) $display("%0t: pos_z exp %0d got %0d", $time, want.pz, got.pz);
        if (got.qw !== want.qw) $display("%0t: quat_w exp %0d got %0d", $time, want.qw, got.qw);
        if (got.qx !== want.qx) $display("%0t: quat_x exp %0d got %0d", $time, want.qx, got.qx);
        if (got.qy !== want.qy) $display("%0t: quat_y exp %0d got %0d", $time, want.qy, got.qy);
        if (got.qz !== want.qz) $display("%0t: quat_z exp %0d got %0d", $time, want.qz, got.qz);
        if (got !== want) errors++;
      end
    end
  end

  initial begin
    map_off[0] = OFFSET_X_RST;
    map_off[1] = OFFSET_Y_RST;
    map_off[2] = OFFSET_Z_RST;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_angles();
    send_random(30);
    test_offset_extremes();
    test_random_traffic();
    test_backpressure();
    quiesce();
    $display("Covered %0d poses (%0d checked): angle quadrants and wrap, saturation,",
             poses_sent, poses_checked);
    $display("offset extremes via APB, random idling and a long output stall.");
    if (errors == 0 && pending_poses.size() == 0) begin
      $display("euler_pose_to_quaternion test passed");
    end else begin
      $display("euler_pose_to_quaternion test failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("euler_pose_to_quaternion test failed");
    $finish;
  end

endmodule
